// ===== src/dxt_pkg.sv =====
// Shared types, format codes and constant-divide helpers for the DXT block decoder.
package dxt_pkg;

  // Block format codes held in the format register
  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2
  } fmt_t;

  // One colour as blue, green, red bytes
  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } bgr_t;

  // One compressed block as it arrives
  typedef struct packed {
    logic [63:0] color_bits;
    logic [63:0] alpha_bits;
  } blk_t;

  // Block after endpoint expansion and alpha palette build
  typedef struct packed {
    bgr_t            ep0;
    bgr_t            ep1;
    logic            four_col;
    logic [31:0]     cidx;
    logic [7:0][7:0] apal;
    logic [63:0]     alpha_bits;
  } exp_t;

  // Block with full colour and alpha palettes
  typedef struct packed {
    bgr_t [3:0]      cpal;
    logic            four_col;
    logic [31:0]     cidx;
    logic [7:0][7:0] apal;
    logic [63:0]     alpha_bits;
  } pal_t;

  // One decoded pixel
  typedef struct packed {
    logic [3:0] pixel_index;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       last_pixel;
  } pix_t;

  localparam logic [3:0] LAST_PIX = 4'd15;

  // x*255/31, truncated, by reciprocal multiply (exact for x < 32)
  function automatic logic [7:0] expand5(input logic [4:0] x);
    logic [26:0] p;
    p = 27'(x) * 27'd2156535;
    return p[25:18];
  endfunction

  // x*255/63, truncated, by reciprocal multiply (exact for x < 64)
  function automatic logic [7:0] expand6(input logic [5:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'd4244475;
    return p[27:20];
  endfunction

  // v/3 for v <= 765
  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [20:0] p;
    p = 21'(v) * 21'd683;
    return p[18:11];
  endfunction

  // v/5 for v <= 1275
  function automatic logic [7:0] div5(input logic [10:0] v);
    logic [21:0] p;
    p = 22'(v) * 22'd1639;
    return p[20:13];
  endfunction

  // v/7 for v <= 1785
  function automatic logic [7:0] div7(input logic [10:0] v);
    logic [24:0] p;
    p = 25'(v) * 25'd2341;
    return p[21:14];
  endfunction

endpackage

// ===== src/dxt_if.sv =====
// Valid/ready channel interfaces for compressed blocks and decoded pixels.
interface dxt_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] color_bits;
  logic [63:0] alpha_bits;

  modport source (output valid, output color_bits, output alpha_bits, input ready);
  modport sink   (input valid, input color_bits, input alpha_bits, output ready);
endinterface

interface dxt_pix_if;
  logic       valid;
  logic       ready;
  logic [3:0] pixel_index;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] alpha;
  logic       last_pixel;

  modport source (output valid, output pixel_index, output blue, output green,
                  output red, output alpha, output last_pixel, input ready);
  modport sink   (input valid, input pixel_index, input blue, input green,
                  input red, input alpha, input last_pixel, output ready);
endinterface

// ===== src/dxt_block_decoder_unit.sv =====
// Top level of the DXT1/DXT3/DXT5 block decoder.
//
//  channel   dir  handshake     payload
//  blocks    in   valid/ready   color_bits[63:0], alpha_bits[63:0]
//  pixels    out  valid/ready   pixel_index, blue, green, red, alpha, last_pixel
//  cfg       in   cfg_wr_en     cfg_wr_data[1:0] -> block format
//
// Each block gives sixteen pixel words, one per cycle while pixels.ready is high;
// the pixel sequencer stepping through the held palette sets this rate.
// Registers in order: input, expanded-block, palette, block holding, result.
// rst is synchronous: it empties all stages and sets the format to DXT1.
// A stalled pixel channel holds the current word; up to three further blocks
// queue in the expand and palette stages before blocks.ready drops.
module dxt_block_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  dxt_blk_if.sink    blocks,
  dxt_pix_if.source  pixels
);
  import dxt_pkg::*;

  logic [1:0] block_format;
  blk_t       blk_in;
  logic       e_valid;
  logic       e_ready;
  exp_t       e_data;
  logic       p_valid;
  logic       p_ready;
  pal_t       p_data;
  pix_t       pix;

  // format register
  always_ff @(posedge clk) begin
    if (rst) begin
      block_format <= FMT_DXT1;
    end else if (cfg_wr_en) begin
      block_format <= cfg_wr_data;
    end
  end

  assign blk_in.color_bits = blocks.color_bits;
  assign blk_in.alpha_bits = blocks.alpha_bits;

  dxt_expand u_expand (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (blocks.valid),
    .in_data   (blk_in),
    .in_ready  (blocks.ready),
    .out_valid (e_valid),
    .out_data  (e_data),
    .out_ready (e_ready)
  );

  dxt_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (e_valid),
    .in_data   (e_data),
    .in_ready  (e_ready),
    .out_valid (p_valid),
    .out_data  (p_data),
    .out_ready (p_ready)
  );

  dxt_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .fmt       (block_format),
    .in_valid  (p_valid),
    .in_data   (p_data),
    .in_ready  (p_ready),
    .out_valid (pixels.valid),
    .out_data  (pix),
    .out_ready (pixels.ready)
  );

  assign pixels.pixel_index = pix.pixel_index;
  assign pixels.blue        = pix.blue;
  assign pixels.green       = pix.green;
  assign pixels.red         = pix.red;
  assign pixels.alpha       = pix.alpha;
  assign pixels.last_pixel  = pix.last_pixel;

endmodule

// ===== src/dxt_expand.sv =====
// Input register, RGB565 endpoint expansion and DXT5 alpha palette stage.
module dxt_expand (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  dxt_pkg::blk_t in_data,
  output logic          in_ready,
  output logic          out_valid,
  output dxt_pkg::exp_t out_data,
  input  logic          out_ready
);
  import dxt_pkg::*;

  logic a_valid;
  blk_t a_blk;
  logic a_ready;
  logic e_load;
  exp_t e_next;

  logic [15:0] e0;
  logic [15:0] e1;
  logic [7:0]  a0;
  logic [7:0]  a1;

  assign e_load   = !out_valid || out_ready;
  assign a_ready  = !a_valid || e_load;
  assign in_ready = a_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
    if (a_ready && in_valid) begin
      a_blk <= in_data;
    end
  end

  assign e0 = a_blk.color_bits[15:0];
  assign e1 = a_blk.color_bits[31:16];
  assign a0 = a_blk.alpha_bits[7:0];
  assign a1 = a_blk.alpha_bits[15:8];

  // endpoints and alpha palette
  always_comb begin
    e_next.ep0.b      = expand5(e0[4:0]);
    e_next.ep0.g      = expand6(e0[10:5]);
    e_next.ep0.r      = expand5(e0[15:11]);
    e_next.ep1.b      = expand5(e1[4:0]);
    e_next.ep1.g      = expand6(e1[10:5]);
    e_next.ep1.r      = expand5(e1[15:11]);
    e_next.four_col   = (e0 > e1);
    e_next.cidx       = a_blk.color_bits[63:32];
    e_next.alpha_bits = a_blk.alpha_bits;
    e_next.apal[0]    = a0;
    e_next.apal[1]    = a1;
    if (a0 > a1) begin
      // seven-step ramp
      for (int i = 0; i < 6; i++) begin
        e_next.apal[2 + i] = div7(11'(a0) * 11'(6 - i) + 11'(a1) * 11'(1 + i));
      end
    end else begin
      // five-step ramp plus fully transparent and fully opaque
      for (int i = 0; i < 4; i++) begin
        e_next.apal[2 + i] = div5(11'(a0) * 11'(4 - i) + 11'(a1) * 11'(1 + i));
      end
      e_next.apal[6] = 8'd0;
      e_next.apal[7] = 8'd255;
    end
  end

  // expanded-block register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (e_load) begin
      out_valid <= a_valid;
    end
    if (e_load && a_valid) begin
      out_data <= e_next;
    end
  end

endmodule

// ===== src/dxt_interp.sv =====
// Colour palette stage: interpolated entries two and three from the endpoints.
module dxt_interp (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  dxt_pkg::exp_t in_data,
  output logic          in_ready,
  output logic          out_valid,
  output dxt_pkg::pal_t out_data,
  input  logic          out_ready
);
  import dxt_pkg::*;

  pal_t p_next;

  // (2*c0 + c1) / 3
  function automatic logic [7:0] third(input logic [7:0] c0, input logic [7:0] c1);
    return div3({1'b0, c0, 1'b0} + 10'(c1));
  endfunction

  // (c0 + c1) / 2
  function automatic logic [7:0] half(input logic [7:0] c0, input logic [7:0] c1);
    logic [8:0] s;
    s = 9'(c0) + 9'(c1);
    return s[8:1];
  endfunction

  assign in_ready = !out_valid || out_ready;

  // four-colour or three-colour-plus-black palette
  always_comb begin
    p_next.cpal[0]    = in_data.ep0;
    p_next.cpal[1]    = in_data.ep1;
    p_next.four_col   = in_data.four_col;
    p_next.cidx       = in_data.cidx;
    p_next.apal       = in_data.apal;
    p_next.alpha_bits = in_data.alpha_bits;
    if (in_data.four_col) begin
      p_next.cpal[2].b = third(in_data.ep0.b, in_data.ep1.b);
      p_next.cpal[2].g = third(in_data.ep0.g, in_data.ep1.g);
      p_next.cpal[2].r = third(in_data.ep0.r, in_data.ep1.r);
      p_next.cpal[3].b = third(in_data.ep1.b, in_data.ep0.b);
      p_next.cpal[3].g = third(in_data.ep1.g, in_data.ep0.g);
      p_next.cpal[3].r = third(in_data.ep1.r, in_data.ep0.r);
    end else begin
      p_next.cpal[2].b = half(in_data.ep0.b, in_data.ep1.b);
      p_next.cpal[2].g = half(in_data.ep0.g, in_data.ep1.g);
      p_next.cpal[2].r = half(in_data.ep0.r, in_data.ep1.r);
      p_next.cpal[3]   = '0;
    end
  end

  // palette register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= p_next;
    end
  end

endmodule

// ===== src/dxt_serial.sv =====
// Pixel sequencer: holds one block's palettes and emits sixteen pixels in raster order.
module dxt_serial (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    fmt,
  input  logic          in_valid,
  input  dxt_pkg::pal_t in_data,
  output logic          in_ready,
  output logic          out_valid,
  output dxt_pkg::pix_t out_data,
  input  logic          out_ready
);
  import dxt_pkg::*;

  logic       pvalid;
  pal_t       pal;
  logic [3:0] cnt;
  logic       ld;
  logic [1:0] ci;
  logic [3:0] a4;
  logic [2:0] ai;
  pix_t       pix_next;

  assign ld       = pvalid && (!out_valid || out_ready);
  assign in_ready = !pvalid || (ld && cnt == LAST_PIX);

  // block holding register and pixel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
      cnt    <= '0;
    end else begin
      if (in_ready) begin
        pvalid <= in_valid;
      end
      if (ld) begin
        cnt <= cnt + 4'd1;
      end
    end
    if (in_ready && in_valid) begin
      pal <= in_data;
    end
  end

  // per-pixel index fields
  assign ci = pal.cidx[{cnt, 1'b0} +: 2];
  assign a4 = pal.alpha_bits[{cnt, 2'b00} +: 4];
  assign ai = pal.alpha_bits[6'd16 + {2'b00, cnt} + {1'b0, cnt, 1'b0} +: 3];

  // pixel decode
  always_comb begin
    pix_next.pixel_index = cnt;
    pix_next.blue        = pal.cpal[ci].b;
    pix_next.green       = pal.cpal[ci].g;
    pix_next.red         = pal.cpal[ci].r;
    pix_next.last_pixel  = (cnt == LAST_PIX);
    unique case (fmt)
      FMT_DXT1: pix_next.alpha = (ci == 2'd3 && !pal.four_col) ? 8'd0 : 8'd255;
      FMT_DXT3: pix_next.alpha = {a4, a4};
      default:  pix_next.alpha = pal.apal[ai];
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= pvalid;
    end
    if (ld) begin
      out_data <= pix_next;
    end
  end

  // counter only runs while a block is held
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    !pvalid |-> cnt == 4'd0)
    else $error("pixel counter non-zero with no block held");

  // pixels of a block come out in order
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (ld && cnt != LAST_PIX) |=> cnt == $past(cnt) + 4'd1)
    else $error("pixel counter skipped");

  // a non-final pixel leaves its block still held
  a_blk_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.last_pixel) |-> pvalid)
    else $error("block released before its last pixel");

endmodule

// ===== test/dxt_block_decoder_unit_tb.sv =====
// Self-checking testbench for the DXT block decoder: block driver, pixel monitor, predictor.
module dxt_block_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dxt_pkg::*;

  localparam logic [1:0] FMT_RESERVED = 2'd3;  // undefined code, decodes as DXT5
  localparam int PROBE_COUNT = 6;
  localparam int RANDOM_PER_PHASE = 41;
  localparam int LONG_HOLD_AT_BLOCK = 60;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [1:0] cfg_wr_data;

  dxt_blk_if blk_ch ();
  dxt_pix_if pix_ch ();

  dxt_block_decoder_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .blocks(blk_ch),
    .pixels(pix_ch)
  );

  blk_t pending_blocks[$];
  pix_t expected_pixels[$];
  blk_t probe_blocks[PROBE_COUNT];

  logic [1:0] fmt_model;
  int blocks_accepted;
  int words_checked;
  int fmt_writes;
  int mismatches;
  int src_gap_left;
  int snk_gap_left;
  int stretch_left;
  int long_hold_left;
  int idle_cycles;
  bit long_hold_done;
  bit src_idle_on;
  bit snk_idle_on;
  bit quiet_tail;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // One line per mismatch, printing capped
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < 20)
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Decode one block and queue its sixteen pixel words
  function automatic void predict_pixels(input logic [63:0] cbits, input logic [63:0] abits,
                                         input logic [1:0] fmt);
    int unsigned cpal[4][4];  // [colour index][B, G, R, A]
    int unsigned apal[8];
    int unsigned a0;
    int unsigned a1;
    int unsigned alpha;
    logic [15:0] ep;
    logic [1:0] ci;
    bit four_col;
    four_col = cbits[15:0] > cbits[31:16];
    for (int k = 0; k < 2; k++) begin
      ep = (k == 0) ? cbits[15:0] : cbits[31:16];
      cpal[k][0] = ep[4:0] * 255 / 31;
      cpal[k][1] = ep[10:5] * 255 / 63;
      cpal[k][2] = ep[15:11] * 255 / 31;
      cpal[k][3] = 255;
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (four_col) begin
        cpal[2][ch] = (2 * cpal[0][ch] + cpal[1][ch]) / 3;
        cpal[3][ch] = (cpal[0][ch] + 2 * cpal[1][ch]) / 3;
      end else begin
        cpal[2][ch] = (cpal[0][ch] + cpal[1][ch]) / 2;
        cpal[3][ch] = 0;
      end
    end
    cpal[2][3] = 255;
    cpal[3][3] = four_col ? 255 : 0;

    // DXT5 alpha palette: seven-step or five-step with 0 and 255 ends
    a0 = abits[7:0];
    a1 = abits[15:8];
    apal[0] = a0;
    apal[1] = a1;
    if (a0 > a1) begin
      for (int i = 0; i < 6; i++)
        apal[2 + i] = ((6 - i) * a0 + (1 + i) * a1) / 7;
    end else begin
      for (int i = 0; i < 4; i++)
        apal[2 + i] = ((4 - i) * a0 + (1 + i) * a1) / 5;
      apal[6] = 0;
      apal[7] = 255;
    end

    for (int i = 0; i < 16; i++) begin
      ci = cbits[32 + 2 * i +: 2];
      if (fmt == FMT_DXT1)
        alpha = cpal[ci][3];
      else if (fmt == FMT_DXT3)
        alpha = abits[4 * i +: 4] * 255 / 15;
      else
        alpha = apal[abits[16 + 3 * i +: 3]];
      expected_pixels.push_back('{pixel_index: 4'(i), blue: 8'(cpal[ci][0]),
                                  green: 8'(cpal[ci][1]), red: 8'(cpal[ci][2]),
                                  alpha: 8'(alpha), last_pixel: (i == 15)});
    end
  endfunction

  // Random on/off stretches for idling on both sides
  always @(posedge clk) begin
    if (stretch_left == 0) begin
      stretch_left <= $urandom_range(16, 64);
      src_idle_on <= $urandom_range(0, 2) != 0;
      snk_idle_on <= $urandom_range(0, 2) != 0;
    end else begin
      stretch_left <= stretch_left - 1;
    end
  end

  // Block driver: takes from the pending queue, predicts on accept
  always @(posedge clk) begin : block_driver
    blk_t nxt;
    if (rst) begin
      blk_ch.valid <= 1'b0;
      src_gap_left <= 0;
    end else begin
      if (blk_ch.valid && blk_ch.ready) begin
        predict_pixels(blk_ch.color_bits, blk_ch.alpha_bits, fmt_model);
        blocks_accepted <= blocks_accepted + 1;
      end
      if (!(blk_ch.valid && !blk_ch.ready)) begin
        if (src_gap_left != 0) begin
          blk_ch.valid <= 1'b0;
          src_gap_left <= src_gap_left - 1;
        end else if (src_idle_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
          blk_ch.valid <= 1'b0;
          src_gap_left <= $urandom_range(0, 4);
        end else if (pending_blocks.size() != 0) begin
          nxt = pending_blocks.pop_front();
          blk_ch.valid <= 1'b1;
          blk_ch.color_bits <= nxt.color_bits;
          blk_ch.alpha_bits <= nxt.alpha_bits;
        end else begin
          blk_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor: checks each word against the oldest expectation, drives ready
  always @(posedge clk) begin : pixel_monitor
    pix_t want;
    if (rst) begin
      pix_ch.ready <= 1'b0;
      snk_gap_left <= 0;
      long_hold_left <= 0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected pixel word, index", pix_ch.pixel_index, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (pix_ch.pixel_index !== want.pixel_index)
            report_mismatch("pixel_index", pix_ch.pixel_index, want.pixel_index);
          if (pix_ch.blue !== want.blue)
            report_mismatch("blue", pix_ch.blue, want.blue);
          if (pix_ch.green !== want.green)
            report_mismatch("green", pix_ch.green, want.green);
          if (pix_ch.red !== want.red)
            report_mismatch("red", pix_ch.red, want.red);
          if (pix_ch.alpha !== want.alpha)
            report_mismatch("alpha", pix_ch.alpha, want.alpha);
          if (pix_ch.last_pixel !== want.last_pixel)
            report_mismatch("last_pixel", pix_ch.last_pixel, want.last_pixel);
        end
        words_checked <= words_checked + 1;
      end
      // one long hold-off to back the block up to its input
      if (long_hold_left != 0) begin
        pix_ch.ready <= 1'b0;
        long_hold_left <= long_hold_left - 1;
      end else if (!long_hold_done && blocks_accepted >= LONG_HOLD_AT_BLOCK) begin
        long_hold_done <= 1'b1;
        long_hold_left <= LONG_HOLD_CYCLES - 1;
        pix_ch.ready <= 1'b0;
      end else if (snk_gap_left != 0) begin
        pix_ch.ready <= 1'b0;
        snk_gap_left <= snk_gap_left - 1;
      end else if (snk_idle_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
        pix_ch.ready <= 1'b0;
        snk_gap_left <= $urandom_range(0, 4);
      end else begin
        pix_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (blk_ch.valid && blk_ch.ready) || (pix_ch.valid && pix_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timed out after %0d cycles with no word accepted", idle_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Wait for an empty queue and no word in flight, checked again after the drain gap
  // since the driver may launch the last block on the very edge the check runs
  task automatic wait_drained();
    do begin
      while (pending_blocks.size() != 0 || expected_pixels.size() != 0 || blk_ch.valid)
        @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end while (pending_blocks.size() != 0 || expected_pixels.size() != 0 || blk_ch.valid);
  endtask

  // Drain, set the format while idle, then queue directed or random blocks
  task automatic run_phase(input logic [1:0] fmt, input bit directed, input int n_items);
    logic [63:0] cbits;
    logic [63:0] abits;
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= fmt;
    fmt_model = fmt;
    fmt_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (directed) begin
      foreach (probe_blocks[k]) pending_blocks.push_back(probe_blocks[k]);
    end else begin
      for (int n = 0; n < n_items; n++) begin
        cbits = {$urandom, $urandom};
        abits = {$urandom, $urandom};
        // lean towards the corner modes now and then
        case ($urandom_range(0, 7))
          0: cbits[31:16] = cbits[15:0];
          1: abits[15:8] = abits[7:0];
          2: cbits[31:0] = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                            $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
          3: cbits[63:32] = '1;
          default: ;
        endcase
        pending_blocks.push_back('{color_bits: cbits, alpha_bits: abits});
      end
    end
  endtask

  // Stimulus and end of run
  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = FMT_DXT1;
    fmt_model = FMT_DXT1;
    blk_ch.valid = 1'b0;
    blk_ch.color_bits = '0;
    blk_ch.alpha_bits = '0;
    pix_ch.ready = 1'b0;

    // all zero; all ones (equal endpoints, transparent index everywhere)
    probe_blocks[0] = '{color_bits: 64'h0, alpha_bits: 64'h0};
    probe_blocks[1] = '{color_bits: 64'hFFFF_FFFF_FFFF_FFFF, alpha_bits: 64'hFFFF_FFFF_FFFF_FFFF};
    // four colours, indices 0..3; seven-step alpha, indices 0..7
    probe_blocks[2] = '{color_bits: 64'hE4E4_E4E4_0000_FFFF, alpha_bits: 64'hFAC6_88FA_C688_00FF};
    // three colours with transparent black; five-step alpha, indices 7..0
    probe_blocks[3] = '{color_bits: 64'h1B1B_1B1B_FFFF_0000, alpha_bits: 64'h0539_7705_3977_FF00};
    // pure red over pure green, index 3 only; seven-step mid-range alpha
    probe_blocks[4] = '{color_bits: 64'hFFFF_FFFF_07E0_F800, alpha_bits: 64'h0539_77FA_C688_4080};
    // equal endpoints, midpoint index; explicit alpha nibbles 0..15
    probe_blocks[5] = '{color_bits: 64'hAAAA_AAAA_001F_001F, alpha_bits: 64'hFEDC_BA98_7654_3210};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    run_phase(FMT_DXT1, 1'b1, 0);
    run_phase(FMT_DXT3, 1'b1, 0);
    run_phase(FMT_DXT5, 1'b1, 0);
    run_phase(FMT_RESERVED, 1'b1, 0);
    run_phase(FMT_DXT5, 1'b0, RANDOM_PER_PHASE);
    run_phase(FMT_DXT1, 1'b0, RANDOM_PER_PHASE);
    run_phase(FMT_DXT3, 1'b0, RANDOM_PER_PHASE);
    run_phase(FMT_RESERVED, 1'b0, RANDOM_PER_PHASE);
    run_phase(FMT_DXT1, 1'b0, RANDOM_PER_PHASE);
    run_phase(FMT_DXT5, 1'b0, RANDOM_PER_PHASE);
    quiet_tail = 1'b1;
    run_phase(FMT_DXT3, 1'b0, RANDOM_PER_PHASE);

    wait_drained();
    if (expected_pixels.size() != 0)
      report_mismatch("pixel words still outstanding", 0, expected_pixels.size());

    $display("Decoded %0d blocks into %0d pixel words over %0d format settings, codes 0 to 3,",
             blocks_accepted, words_checked, fmt_writes);
    $display("with random stalls on both channels, one long output hold-off and a stall-free tail.");
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
